// ===== sv/qmbb_pkg.sv =====
// Shared types, constants and helpers for the quad motor bang-bang mixer.
package qmbb_pkg;

    localparam int unsigned VEC_W   = 16;
    localparam int unsigned YAW_W   = 8;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned MOTORS  = 4;
    localparam int unsigned IN_W    = 6 * VEC_W + YAW_W;
    localparam int unsigned OUT_W   = MOTORS * DUTY_W;

    // Motor slots, lowest first.
    localparam int unsigned MOTOR_FL = 0;
    localparam int unsigned MOTOR_FR = 1;
    localparam int unsigned MOTOR_BR = 2;
    localparam int unsigned MOTOR_BL = 3;

    // Motors that step up when norm exceeds target on X or on Y.
    localparam logic [MOTORS-1:0] X_UP_ON_GT = 4'b0011;
    localparam logic [MOTORS-1:0] Y_UP_ON_GT = 4'b0110;
    // Motors that take +(last_yaw - yaw_cmd) in the yaw mix; the rest take the negation.
    localparam logic [MOTORS-1:0] YAW_ADD    = 4'b1001;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd0;

    typedef logic [MOTORS-1:0][DUTY_W-1:0] duty_vec_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] norm_x;
        logic signed [VEC_W-1:0] norm_y;
        logic signed [VEC_W-1:0] norm_z;
        logic signed [VEC_W-1:0] target_x;
        logic signed [VEC_W-1:0] target_y;
        logic signed [VEC_W-1:0] target_z;
        logic signed [YAW_W-1:0] yaw_cmd;
    } item_t;

    typedef struct packed {
        duty_vec_t               thrust;
        logic signed [YAW_W-1:0] last_yaw;
        duty_vec_t               drive;
    } step_t;

    // One saturating step of a thrust value.
    function automatic logic [DUTY_W-1:0] bump(input logic [DUTY_W-1:0] t,
                                                input logic up, input logic dn);
        logic [DUTY_W-1:0] r;
        r = t;
        if (up && t != DUTY_MAX)
        begin
            r = t + 8'd1;
        end
        else if (dn && t != DUTY_MIN)
        begin
            r = t - 8'd1;
        end
        return r;
    endfunction

endpackage

// ===== sv/quad_motor_bang_bang_mixer_unit.sv =====
// Top level of the quad motor bang-bang mixer: input stage, state and result register.
// Path: a word accepted into the input register moves on into the result register once
// that is free, and the output side takes it from there.
// Throughput: one word per cycle; the input register feeds the thrust update logic and
// the result register, so the only limit is the output side taking its words.
// Reset (rst_n low, asynchronous) empties both stages and clears the four thrusts and
// the stored yaw to zero.
module quad_motor_bang_bang_mixer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0 up: norm_x, norm_y, norm_z, target_x, target_y, target_z
    // (16 bits each, signed), yaw_cmd (8 bits, signed).
    input  logic [qmbb_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0 up: drive_front_left, drive_front_right, drive_back_right,
    // drive_back_left (8 bits each, unsigned).
    output logic [qmbb_pkg::OUT_W-1:0]  m_axis_tdata
);

    // Input stage: the accepted word waits here until the result register is free.
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    qmbb_pkg::item_t                      s1_item_reg;
    qmbb_pkg::item_t                      in_item;

    // Motor state carried from word to word.
    qmbb_pkg::duty_vec_t                  thrust_reg;
    logic signed [qmbb_pkg::YAW_W-1:0]    last_yaw_reg;

    // Result register.
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    qmbb_pkg::duty_vec_t                  drive_reg;

    qmbb_pkg::step_t                      step;
    logic                                 s_fire;
    logic                                 s1_fire;

    // Unpack the input word, lowest field first.
    assign in_item.norm_x   = s_axis_tdata[15:0];
    assign in_item.norm_y   = s_axis_tdata[31:16];
    assign in_item.norm_z   = s_axis_tdata[47:32];
    assign in_item.target_x = s_axis_tdata[63:48];
    assign in_item.target_y = s_axis_tdata[79:64];
    assign in_item.target_z = s_axis_tdata[95:80];
    assign in_item.yaw_cmd  = s_axis_tdata[103:96];

    // The staged word moves on whenever the result register is empty or being drained.
    // The input side is open whenever the staged word is leaving or there is none, so
    // a new word is taken in every cycle while the output keeps up.
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next  = s_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !m_axis_tready);

    qmbb_core u_core (
        .item     (s1_item_reg),
        .thrust   (thrust_reg),
        .last_yaw (last_yaw_reg),
        .step     (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thrust_reg    <= '0;
            last_yaw_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // The thrusts and the stored yaw advance exactly once per word, as it
            // moves into the result register.
            if (s1_fire)
            begin
                thrust_reg   <= step.thrust;
                last_yaw_reg <= step.last_yaw;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_fire)
        begin
            drive_reg <= step.drive;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_reg;

`ifndef SYNTHESIS
    // Motor state must only move when a word passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(thrust_reg) && $stable(last_yaw_reg))
        else $error("motor state changed without a word passing through");

    // A zero yaw command leaves the stored yaw alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_item_reg.yaw_cmd == '0 |=> $stable(last_yaw_reg))
        else $error("stored yaw changed on a zero yaw command");

    // Without a yaw command the drives are the freshly updated thrusts.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_item_reg.yaw_cmd == '0 |=> drive_reg == thrust_reg)
        else $error("drive differs from thrust on a word without yaw");

    // A word leaving the input stage always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("result register empty after a word moved into it");

    // The input stage never drops a word: it stays full unless it moved on.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("staged word lost or altered while stalled");
`endif

endmodule

// ===== sv/qmbb_core.sv =====
// Combinational thrust update and yaw mix for one word.
module qmbb_core (
    input  qmbb_pkg::item_t               item,
    input  qmbb_pkg::duty_vec_t           thrust,
    input  logic signed [qmbb_pkg::YAW_W-1:0] last_yaw,
    output qmbb_pkg::step_t               step
);

    logic gt_x, lt_x, gt_y, lt_y, gt_z, lt_z;
    logic yaw_active;
    logic signed [qmbb_pkg::YAW_W:0] yaw_delta;
    logic signed [10:0]              yaw_delta_ext;
    qmbb_pkg::duty_vec_t             after_x, after_y, after_z;
    logic signed [10:0]              mix [qmbb_pkg::MOTORS];

    assign gt_x = item.norm_x > item.target_x;
    assign lt_x = item.norm_x < item.target_x;
    assign gt_y = item.norm_y > item.target_y;
    assign lt_y = item.norm_y < item.target_y;
    assign gt_z = item.norm_z > item.target_z;
    assign lt_z = item.norm_z < item.target_z;

    assign yaw_active    = item.yaw_cmd != '0;
    assign yaw_delta     = 9'(last_yaw) - 9'(item.yaw_cmd);
    assign yaw_delta_ext = 11'(yaw_delta);

    // Each axis saturates on the result of the one before, so the steps chain.
    always_comb
    begin
        for (int m = 0; m < qmbb_pkg::MOTORS; m++)
        begin
            after_x[m] = qmbb_pkg::bump(thrust[m],
                             qmbb_pkg::X_UP_ON_GT[m] ? gt_x : lt_x,
                             qmbb_pkg::X_UP_ON_GT[m] ? lt_x : gt_x);
            after_y[m] = qmbb_pkg::bump(after_x[m],
                             qmbb_pkg::Y_UP_ON_GT[m] ? gt_y : lt_y,
                             qmbb_pkg::Y_UP_ON_GT[m] ? lt_y : gt_y);
            after_z[m] = qmbb_pkg::bump(after_y[m], lt_z, gt_z);
        end
    end

    always_comb
    begin
        for (int m = 0; m < qmbb_pkg::MOTORS; m++)
        begin
            if (qmbb_pkg::YAW_ADD[m])
            begin
                mix[m] = $signed({3'b000, after_z[m]}) + yaw_delta_ext;
            end
            else
            begin
                mix[m] = $signed({3'b000, after_z[m]}) - yaw_delta_ext;
            end
            if (!yaw_active)
            begin
                step.drive[m] = after_z[m];
            end
            else if (mix[m][10])
            begin
                step.drive[m] = qmbb_pkg::DUTY_MIN;
            end
            else if (mix[m][9:8] != 2'b00)
            begin
                step.drive[m] = qmbb_pkg::DUTY_MAX;
            end
            else
            begin
                step.drive[m] = mix[m][7:0];
            end
        end
        step.thrust   = after_z;
        step.last_yaw = yaw_active ? item.yaw_cmd : last_yaw;
    end

endmodule
